>>> rtl/lik_pkg.sv
// shared types, constants and arctangent table for the leg inverse kinematics block
package lik_pkg;

   typedef struct packed {
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
      logic signed [23:0] target_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] hip_yaw;
      logic signed [15:0] femur_pitch;
      logic signed [15:0] knee_angle;
      logic [1:0]         reach_status;
   } rsp_type;

   typedef enum logic [1:0] {
      REACH_OK    = 2'd0,
      REACH_CLOSE = 2'd1,
      REACH_FAR   = 2'd2
   } reach_type;

   typedef enum logic [1:0] {
      CSR_COXA  = 2'd0,
      CSR_FEMUR = 2'd1,
      CSR_TIBIA = 2'd2
   } csr_type;

   localparam logic [15:0] COXA_RESET  = 16'd12800;
   localparam logic [15:0] FEMUR_RESET = 16'd25600;
   localparam logic [15:0] TIBIA_RESET = 16'd25600;

   localparam int CORDIC_W       = 46;
   localparam int CORDIC_IN_W    = 26;
   localparam int ANGLE_W        = 34;
   localparam int NORM_EXP       = 41;
   localparam int NORM_STAGES    = 6;
   localparam int CORDIC_FIX_LAT = 1 + NORM_STAGES;
   localparam int ATAN_ENTRIES   = 24;

   localparam int SQRT_IN_W  = 50;
   localparam int SQRT_OUT_W = 25;
   localparam int SQRT_LAT   = SQRT_OUT_W;

   localparam int DIV_NUM_W = 52;
   localparam int DIV_DEN_W = 42;
   localparam int DIV_Q_W   = 24;
   localparam int COS_W     = 26;
   localparam int DIV_LAT   = DIV_Q_W + 2;

   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [35:0]        PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0]        TWO_PI_Q30  = 36'sd6746518852;

   localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

endpackage

>>> rtl/lik_delay.sv
// fixed-depth delay line with shared stall enable
module lik_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

>>> rtl/lik_isqrt.sv
// pipelined floor integer square root, one root bit per stage
module lik_isqrt import lik_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic [SQRT_IN_W-1:0]  rad_in,
   output logic [SQRT_OUT_W-1:0] root_out
);

   localparam int N     = SQRT_OUT_W;
   localparam int REM_W = N + 2;

   logic [SQRT_IN_W-1:0] rad_ff  [N];
   logic [REM_W-1:0]     rem_ff  [N];
   logic [N-1:0]         root_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [SQRT_IN_W-1:0] prad;
      logic [REM_W-1:0]     prem;
      logic [N-1:0]         proot;
      logic [REM_W+1:0]     remt;
      logic [REM_W+1:0]     trial;
      logic                 ge;

      if (j == 0) begin : g_first
         assign prad  = rad_in;
         assign prem  = '0;
         assign proot = '0;
      end else begin : g_next
         assign prad  = rad_ff[j-1];
         assign prem  = rem_ff[j-1];
         assign proot = root_ff[j-1];
      end

      always_comb begin
         remt  = {prem, prad[SQRT_IN_W-1 -: 2]};
         trial = {REM_W'(proot), 2'b01};
         ge    = (remt >= trial);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[j]  <= {prad[SQRT_IN_W-3:0], 2'b00};
            rem_ff[j]  <= ge ? REM_W'(remt - trial) : REM_W'(remt);
            root_ff[j] <= {proot[N-2:0], ge};
         end
      end
   end

   assign root_out = root_ff[N-1];

endmodule

>>> rtl/lik_cosdiv.sv
// pipelined clamped q24 quotient num / den, one quotient bit per stage
module lik_cosdiv import lik_pkg::*; (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0]        den,
   output logic signed [COS_W-1:0]     cosine
);

   localparam int N = DIV_Q_W;

   logic [DIV_NUM_W-1:0] mag;
   logic                 neg_ff   [N+1];
   logic                 clamp_ff [N+1];
   logic [DIV_DEN_W-1:0] den_ff   [N+1];
   logic [DIV_DEN_W-1:0] rem_ff   [N+1];
   logic [N-1:0]         q_ff     [N+1];
   logic [COS_W-1:0]     cmag;
   logic signed [COS_W-1:0] cos_ff;

   assign mag = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);

   // magnitude at or above the denominator clamps to one, also covers a zero denominator
   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0]   <= num[DIV_NUM_W-1];
         clamp_ff[0] <= (mag >= DIV_NUM_W'(den));
         den_ff[0]   <= den;
         rem_ff[0]   <= (mag >= DIV_NUM_W'(den)) ? '0 : mag[DIV_DEN_W-1:0];
         q_ff[0]     <= '0;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_stage
      logic [DIV_DEN_W:0] r2;
      logic               ge;

      always_comb begin
         r2 = {rem_ff[k-1], 1'b0};
         ge = (r2 >= {1'b0, den_ff[k-1]});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[k]   <= neg_ff[k-1];
            clamp_ff[k] <= clamp_ff[k-1];
            den_ff[k]   <= den_ff[k-1];
            rem_ff[k]   <= ge ? DIV_DEN_W'(r2 - {1'b0, den_ff[k-1]}) : DIV_DEN_W'(r2);
            q_ff[k]     <= {q_ff[k-1][N-2:0], ge};
         end
      end
   end

   assign cmag = clamp_ff[N] ? (COS_W'(1) << N) : COS_W'(q_ff[N]);

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= neg_ff[N] ? $signed(-cmag) : $signed(cmag);
      end
   end

   assign cosine = cos_ff;

endmodule

>>> rtl/lik_atan2.sv
// pipelined cordic atan2: half-plane rotation, normalize, vectoring steps
module lik_atan2 import lik_pkg::*; #(
   parameter int STEPS = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [CORDIC_IN_W-1:0] y_in,
   input  logic signed [CORDIC_IN_W-1:0] x_in,
   output logic signed [ANGLE_W-1:0]     angle
);

   localparam int TOT = CORDIC_FIX_LAT + STEPS;

   logic signed [CORDIC_W-1:0] x_ff    [TOT];
   logic signed [CORDIC_W-1:0] y_ff    [TOT];
   logic signed [ANGLE_W-1:0]  z_ff    [TOT];
   logic                       zero_ff [TOT];

   logic signed [CORDIC_W-1:0] xe, ye, rx_in, ry_in;
   logic signed [ANGLE_W-1:0]  rz_in;

   assign xe = CORDIC_W'(x_in);
   assign ye = CORDIC_W'(y_in);

   // left half plane turns by a quarter first
   always_comb begin
      rx_in = xe;
      ry_in = ye;
      rz_in = '0;
      if (xe < 0) begin
         if (ye >= 0) begin
            rx_in = ye;
            ry_in = -xe;
            rz_in = HALF_PI_Q30;
         end else begin
            rx_in = -ye;
            ry_in = xe;
            rz_in = -HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= rx_in;
         y_ff[0]    <= ry_in;
         z_ff[0]    <= rz_in;
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
      end
   end

   // binary normalize: shift by 32,16,..,1 while both stay below the target
   for (genvar g = 1; g <= NORM_STAGES; g++) begin : g_norm
      localparam int SH = 1 << (NORM_STAGES - g);
      localparam logic signed [CORDIC_W-1:0] LIM = CORDIC_W'(1) <<< (NORM_EXP - SH);
      logic fit;

      assign fit = (x_ff[g-1] < LIM) && (x_ff[g-1] > -LIM) &&
                   (y_ff[g-1] < LIM) && (y_ff[g-1] > -LIM);

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[g]    <= fit ? (x_ff[g-1] <<< SH) : x_ff[g-1];
            y_ff[g]    <= fit ? (y_ff[g-1] <<< SH) : y_ff[g-1];
            z_ff[g]    <= z_ff[g-1];
            zero_ff[g] <= zero_ff[g-1];
         end
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      localparam int G = CORDIC_FIX_LAT + i;
      localparam logic signed [ANGLE_W-1:0] ATN = $signed(ANGLE_W'(ATAN_Q30[i]));
      logic signed [CORDIC_W-1:0] sx, sy;

      assign sx = y_ff[G-1] >>> i;
      assign sy = x_ff[G-1] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[G-1] > 0) begin
               x_ff[G] <= x_ff[G-1] + sx;
               y_ff[G] <= y_ff[G-1] - sy;
               z_ff[G] <= z_ff[G-1] + ATN;
            end else begin
               x_ff[G] <= x_ff[G-1] - sx;
               y_ff[G] <= y_ff[G-1] + sy;
               z_ff[G] <= z_ff[G-1] - ATN;
            end
            zero_ff[G] <= zero_ff[G-1];
         end
      end
   end

   assign angle = zero_ff[TOT-1] ? '0 : z_ff[TOT-1];

endmodule

>>> rtl/leg_inverse_kinematics.sv
// leg inverse kinematics top: config registers, geometry stages, angle select and rounding
// throughput: one request per cycle while the response is not stalled, set by the fully
// pipelined cordic, sqrt and divide units
// a stalled response freezes the whole pipeline, no request is lost or repeated
// reset clears all valid bits and loads the segment lengths with their defaults
module leg_inverse_kinematics import lik_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 12,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int LAT_ATAN = CORDIC_FIX_LAT + CORDIC_STEPS;
   localparam int YAW_DLY  = 33 + 2 * SQRT_LAT + DIV_LAT;
   localparam int PHI_DLY  = 30 + SQRT_LAT + DIV_LAT;
   localparam int ST_DLY   = 27 + SQRT_LAT + DIV_LAT + LAT_ATAN;
   localparam int VL       = 34 + 2 * SQRT_LAT + DIV_LAT + LAT_ATAN;
   localparam int RSH      = 30 - ANGLE_FRAC_BITS;

   logic adv;

   // config registers and derived constants
   logic [15:0] coxa_ff, femur_ff, tibia_ff;
   logic [31:0] ffsq_ff, ttsq_ff, losq_ff;
   logic [33:0] hisq_ff;
   logic [32:0] ft2_ff;
   logic signed [16:0] diff;
   logic signed [33:0] diffsq;
   logic [16:0] sum;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coxa_ff  <= COXA_RESET;
         femur_ff <= FEMUR_RESET;
         tibia_ff <= TIBIA_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COXA:  coxa_ff  <= csr_data;
            CSR_FEMUR: femur_ff <= csr_data;
            CSR_TIBIA: tibia_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign diff   = $signed({1'b0, tibia_ff}) - $signed({1'b0, femur_ff});
   assign diffsq = diff * diff;
   assign sum    = {1'b0, femur_ff} + {1'b0, tibia_ff};

   always_ff @(posedge clock) begin
      ffsq_ff <= 32'(femur_ff) * 32'(femur_ff);
      ttsq_ff <= 32'(tibia_ff) * 32'(tibia_ff);
      losq_ff <= diffsq[31:0];
      hisq_ff <= 34'(sum) * 34'(sum);
      ft2_ff  <= {32'(femur_ff) * 32'(tibia_ff), 1'b0};
   end

   // pipeline control
   logic rsp_valid_ff;
   logic v0_ff;
   logic vchain_ff [VL];

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < VL; i++) begin
            vchain_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v0_ff        <= req_valid;
         vchain_ff[0] <= v0_ff;
         for (int i = 1; i < VL; i++) begin
            vchain_ff[i] <= vchain_ff[i-1];
         end
         rsp_valid_ff <= vchain_ff[VL-1];
      end
   end

   // planar radius
   logic signed [23:0] x0_ff, y0_ff, z0_ff;
   logic signed [47:0] xx_full, yy_full;
   logic [46:0] xx_ff, yy_ff;
   logic [47:0] r2_ff;
   logic [SQRT_OUT_W-1:0] r_w;

   assign xx_full = x0_ff * x0_ff;
   assign yy_full = y0_ff * y0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff <= req_payload.target_x;
         y0_ff <= req_payload.target_y;
         z0_ff <= req_payload.target_z;
         xx_ff <= xx_full[46:0];
         yy_ff <= yy_full[46:0];
         r2_ff <= {1'b0, xx_ff} + {1'b0, yy_ff};
      end
   end

   lik_isqrt u_sqrt_r (
      .clock    (clock),
      .en       (adv),
      .rad_in   ({2'b00, r2_ff}),
      .root_out (r_w)
   );

   logic signed [ANGLE_W-1:0] yaw_w, yaw_d;

   lik_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_yaw (
      .clock (clock),
      .en    (adv),
      .y_in  (CORDIC_IN_W'(y0_ff)),
      .x_in  (CORDIC_IN_W'(x0_ff)),
      .angle (yaw_w)
   );

   lik_delay #(.WIDTH(ANGLE_W), .DEPTH(YAW_DLY)) u_dly_yaw (
      .clock (clock), .en (adv), .d (yaw_w), .q (yaw_d)
   );

   // pitch plane projection and reach test
   logic [23:0] z_d;
   logic signed [23:0] zp;
   logic signed [25:0] dy_ff;
   logic signed [51:0] dsq_full;
   logic signed [47:0] zsq_full;
   logic [48:0] dsq_ff;
   logic [46:0] zsq_ff;
   logic [49:0] v2_ff;
   reach_type   stat_in;
   logic [1:0]  stat_ff;
   logic signed [DIV_NUM_W-1:0] numa_ff, numk_ff;

   lik_delay #(.WIDTH(24), .DEPTH(SQRT_LAT + 3)) u_dly_z (
      .clock (clock), .en (adv), .d (z0_ff), .q (z_d)
   );

   assign zp       = $signed(z_d);
   assign dsq_full = dy_ff * dy_ff;
   assign zsq_full = zp * zp;

   always_comb begin
      if (v2_ff < 50'(losq_ff)) begin
         stat_in = REACH_CLOSE;
      end else if (v2_ff > 50'(hisq_ff)) begin
         stat_in = REACH_FAR;
      end else begin
         stat_in = REACH_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dy_ff   <= $signed({1'b0, r_w}) - $signed({10'b0, coxa_ff});
         dsq_ff  <= dsq_full[48:0];
         zsq_ff  <= zsq_full[46:0];
         v2_ff   <= {1'b0, dsq_ff} + {3'b000, zsq_ff};
         stat_ff <= stat_in;
         numa_ff <= $signed({20'b0, ffsq_ff}) - $signed({20'b0, ttsq_ff})
                    + $signed({2'b00, v2_ff});
         numk_ff <= $signed({20'b0, ffsq_ff}) + $signed({20'b0, ttsq_ff})
                    - $signed({2'b00, v2_ff});
      end
   end

   logic signed [ANGLE_W-1:0] phi_w, phi_d;
   logic [1:0] stat_d;

   lik_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_phi (
      .clock (clock),
      .en    (adv),
      .y_in  (CORDIC_IN_W'(zp)),
      .x_in  (dy_ff),
      .angle (phi_w)
   );

   lik_delay #(.WIDTH(ANGLE_W), .DEPTH(PHI_DLY)) u_dly_phi (
      .clock (clock), .en (adv), .d (phi_w), .q (phi_d)
   );

   lik_delay #(.WIDTH(2), .DEPTH(ST_DLY)) u_dly_stat (
      .clock (clock), .en (adv), .d (stat_ff), .q (stat_d)
   );

   // law of cosines quotients
   logic [SQRT_OUT_W-1:0] d_w;
   logic [40:0] fd;
   logic [DIV_DEN_W-1:0] dena_ff;
   logic [DIV_NUM_W-1:0] numa_d, numk_d;

   lik_isqrt u_sqrt_d (
      .clock (clock), .en (adv), .rad_in (v2_ff), .root_out (d_w)
   );

   lik_delay #(.WIDTH(DIV_NUM_W), .DEPTH(SQRT_LAT)) u_dly_numa (
      .clock (clock), .en (adv), .d (numa_ff), .q (numa_d)
   );

   lik_delay #(.WIDTH(DIV_NUM_W), .DEPTH(SQRT_LAT)) u_dly_numk (
      .clock (clock), .en (adv), .d (numk_ff), .q (numk_d)
   );

   assign fd = 41'(femur_ff) * 41'(d_w);

   always_ff @(posedge clock) begin
      if (adv) begin
         dena_ff <= {fd, 1'b0};
      end
   end

   logic signed [COS_W-1:0] ca_w, ck_w;

   lik_cosdiv u_div_a (
      .clock (clock), .en (adv), .num ($signed(numa_d)), .den (dena_ff), .cosine (ca_w)
   );

   lik_cosdiv u_div_k (
      .clock (clock), .en (adv), .num ($signed(numk_d)), .den (DIV_DEN_W'(ft2_ff)),
      .cosine (ck_w)
   );

   // sines from the clamped cosines
   logic signed [51:0] cca_full, cck_full;
   logic [48:0] cca_ff, cck_ff, rada_ff, radk_ff;
   logic [SQRT_OUT_W-1:0] sa_w, sk_w;
   logic [COS_W-1:0] ca_d, ck_d;

   assign cca_full = ca_w * ca_w;
   assign cck_full = ck_w * ck_w;

   always_ff @(posedge clock) begin
      if (adv) begin
         cca_ff  <= cca_full[48:0];
         cck_ff  <= cck_full[48:0];
         rada_ff <= (49'd1 << 48) - cca_ff;
         radk_ff <= (49'd1 << 48) - cck_ff;
      end
   end

   lik_isqrt u_sqrt_sa (
      .clock (clock), .en (adv), .rad_in ({1'b0, rada_ff}), .root_out (sa_w)
   );

   lik_isqrt u_sqrt_sk (
      .clock (clock), .en (adv), .rad_in ({1'b0, radk_ff}), .root_out (sk_w)
   );

   lik_delay #(.WIDTH(COS_W), .DEPTH(SQRT_LAT + 2)) u_dly_ca (
      .clock (clock), .en (adv), .d (ca_w), .q (ca_d)
   );

   lik_delay #(.WIDTH(COS_W), .DEPTH(SQRT_LAT + 2)) u_dly_ck (
      .clock (clock), .en (adv), .d (ck_w), .q (ck_d)
   );

   logic signed [ANGLE_W-1:0] alpha_w, inner_w;

   lik_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_alpha (
      .clock (clock), .en (adv), .y_in ({1'b0, sa_w}), .x_in ($signed(ca_d)),
      .angle (alpha_w)
   );

   lik_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_inner (
      .clock (clock), .en (adv), .y_in ({1'b0, sk_w}), .x_in ($signed(ck_d)),
      .angle (inner_w)
   );

   // joint angle select
   logic signed [35:0] phi36, fsum, fem_in, knee_in;
   logic signed [35:0] fem_ff, knee_ff, yawf_ff;
   logic [1:0] statf_ff;

   assign phi36 = 36'(phi_d);
   assign fsum  = phi36 + 36'(alpha_w);

   always_comb begin
      case (reach_type'(stat_d))
         REACH_CLOSE: begin
            fem_in  = PI_Q30 + phi36;
            knee_in = PI_Q30;
         end
         REACH_FAR: begin
            fem_in  = phi36;
            knee_in = '0;
         end
         default: begin
            fem_in  = (fsum > PI_Q30) ? fsum - TWO_PI_Q30 : fsum;
            knee_in = PI_Q30 - 36'(inner_w);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fem_ff   <= fem_in;
         knee_ff  <= knee_in;
         yawf_ff  <= 36'($signed(yaw_d));
         statf_ff <= stat_d;
      end
   end

   // round half up and saturate
   function automatic logic signed [15:0] round_angle(input logic signed [35:0] a);
      logic signed [36:0] s;
      logic signed [36:0] v;
      s = 37'(a) + (37'sd1 <<< (RSH - 1));
      v = s >>> RSH;
      if (v > 37'sd32767) begin
         round_angle = 16'sh7fff;
      end else if (v < -37'sd32768) begin
         round_angle = 16'sh8000;
      end else begin
         round_angle = v[15:0];
      end
   endfunction

   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.hip_yaw      <= round_angle(yawf_ff);
         rsp_ff.femur_pitch  <= round_angle(fem_ff);
         rsp_ff.knee_angle   <= round_angle(knee_ff);
         rsp_ff.reach_status <= statf_ff;
      end
   end

   assign rsp_payload = rsp_ff;

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v0_ff)
      else $error("accepted request did not enter the pipeline");

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(vchain_ff[VL-1]) && $stable(v0_ff)))
      else $error("pipeline moved while the response was stalled");

   a_far_knee : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.reach_status == REACH_FAR) |-> (rsp_ff.knee_angle == '0))
      else $error("extended leg with nonzero knee angle");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.reach_status != 2'd3))
      else $error("undefined reach status");

endmodule

>>> tb/leg_inverse_kinematics_test.sv
// self-checking testbench for leg_inverse_kinematics: directed table, then random targets per geometry
module leg_inverse_kinematics_test;
   import lik_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int ANGLE_FRAC = 12;
   localparam int ATAN_STEPS = 16;

   typedef enum logic {ROW_TARGET, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      target;
      int           status;
      logic [1:0]   index;
      logic [15:0]  data;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   longint       coxa_len, femur_len, tibia_len;
   rsp_type      angles_pending[$];
   int           status_pending[$];
   stim_row_type rows[$];
   int           errors = 0;
   bit           calm;

   leg_inverse_kinematics DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   // atan2 in units of 2^-30 rad
   function automatic longint vector_angle(longint y, longint x);
      longint z, t, sx, sy, m;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = HALF_PI_Q30;
         end else begin
            t = x; x = -y; y = t; z = -HALF_PI_Q30;
         end
      end
      m = magnitude(x) > magnitude(y) ? magnitude(x) : magnitude(y);
      while (m < (64'sd1 <<< 40)) begin
         x = x * 2;
         y = y * 2;
         m = m * 2;
      end
      for (int i = 0; i < ATAN_STEPS && i < ATAN_ENTRIES; i++) begin
         sx = y >>> i;
         sy = x >>> i;
         if (y > 0) begin
            x += sx; y -= sy; z += longint'(ATAN_Q30[i]);
         end else begin
            x -= sx; y += sy; z -= longint'(ATAN_Q30[i]);
         end
      end
      return z;
   endfunction

   function automatic longint cosine_q24(longint num, longint den);
      longint c;
      if (den == 0) return num < 0 ? -(64'sd1 <<< 24) : (64'sd1 <<< 24);
      c = (num * (64'sd1 <<< 24)) / den;
      if (c > (64'sd1 <<< 24)) c = 64'sd1 <<< 24;
      if (c < -(64'sd1 <<< 24)) c = -(64'sd1 <<< 24);
      return c;
   endfunction

   function automatic longint arc_cosine(longint c);
      longint s;
      s = longint'(int_root(longint'(64'sd1 <<< 48) - c * c));
      return vector_angle(s, c);
   endfunction

   function automatic logic signed [15:0] round_angle(longint a);
      longint v;
      v = (a + (64'sd1 <<< (29 - ANGLE_FRAC))) >>> (30 - ANGLE_FRAC);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic rsp_type solve_leg(req_type p);
      longint x, y, z, yaw, phi, dy, v2, diff, sum, femur, knee, d, alpha, inner;
      rsp_type r;
      x = longint'(p.target_x);
      y = longint'(p.target_y);
      z = longint'(p.target_z);
      yaw = vector_angle(y, x);
      dy = longint'(int_root(x * x + y * y)) - coxa_len;
      v2 = dy * dy + z * z;
      phi = vector_angle(z, dy);
      diff = tibia_len - femur_len;
      sum = femur_len + tibia_len;
      if (v2 < diff * diff) begin
         r.reach_status = REACH_CLOSE;
         femur = longint'(PI_Q30) + phi;
         knee = longint'(PI_Q30);
      end else if (v2 > sum * sum) begin
         r.reach_status = REACH_FAR;
         femur = phi;
         knee = 0;
      end else begin
         d = longint'(int_root(v2));
         alpha = arc_cosine(cosine_q24(femur_len * femur_len - tibia_len * tibia_len + v2,
                                       2 * femur_len * d));
         inner = arc_cosine(cosine_q24(femur_len * femur_len + tibia_len * tibia_len - v2,
                                       2 * femur_len * tibia_len));
         r.reach_status = REACH_OK;
         femur = phi + alpha;
         if (femur > longint'(PI_Q30)) femur -= longint'(TWO_PI_Q30);
         knee = longint'(PI_Q30) - inner;
      end
      r.hip_yaw = round_angle(yaw);
      r.femur_pitch = round_angle(femur);
      r.knee_angle = round_angle(knee);
      return r;
   endfunction

   function automatic req_type make_target(longint x, longint y, longint z);
      req_type p;
      p.target_x = x[23:0];
      p.target_y = y[23:0];
      p.target_z = z[23:0];
      return p;
   endfunction

   function automatic req_type random_target();
      longint span;
      int pick;
      span = coxa_len + femur_len + tibia_len + 64;
      pick = $urandom_range(99);
      if (pick < 75)
         return make_target(longint'($urandom_range(2 * span)) - span,
                            longint'($urandom_range(2 * span)) - span,
                            longint'($urandom_range(2 * span)) - span);
      if (pick < 85)
         return make_target(longint'($urandom_range(16)) - 8, longint'($urandom_range(16)) - 8,
                            longint'($urandom_range(16)) - 8);
      return make_target($urandom, $urandom, $urandom);
   endfunction

   task automatic add_target(longint x, longint y, longint z, int status);
      stim_row_type r;
      r.kind = ROW_TARGET;
      r.target = make_target(x, y, z);
      r.status = status;
      r.index = CSR_SPARE;
      r.data = '0;
      rows.push_back(r);
   endtask

   task automatic add_csr(logic [1:0] index, logic [15:0] data);
      stim_row_type r;
      r.kind = ROW_CSR;
      r.target = '0;
      r.status = -1;
      r.index = index;
      r.data = data;
      rows.push_back(r);
   endtask

   task automatic send_request(req_type p, int status);
      while (!calm && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      angles_pending.push_back(solve_leg(p));
      status_pending.push_back(status);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (angles_pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         CSR_COXA:  coxa_len = data;
         CSR_FEMUR: femur_len = data;
         CSR_TIBIA: tibia_len = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_geometry(logic [15:0] coxa, logic [15:0] femur, logic [15:0] tibia);
      drain();
      write_csr(CSR_COXA, coxa);
      write_csr(CSR_FEMUR, femur);
      write_csr(CSR_TIBIA, tibia);
   endtask

   task automatic report(string field, longint want, longint got);
      errors++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 13);
   end

   always @(posedge clock) begin
      rsp_type want;
      int status;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (angles_pending.size() == 0) begin
            errors++;
            $display("%0t unexpected response %p", $time, rsp_payload);
         end else begin
            want = angles_pending.pop_front();
            status = status_pending.pop_front();
            if (rsp_payload.hip_yaw !== want.hip_yaw)
               report("hip_yaw", want.hip_yaw, rsp_payload.hip_yaw);
            if (rsp_payload.femur_pitch !== want.femur_pitch)
               report("femur_pitch", want.femur_pitch, rsp_payload.femur_pitch);
            if (rsp_payload.knee_angle !== want.knee_angle)
               report("knee_angle", want.knee_angle, rsp_payload.knee_angle);
            if (rsp_payload.reach_status !== want.reach_status)
               report("reach_status", want.reach_status, rsp_payload.reach_status);
            if (status >= 0 && rsp_payload.reach_status !== status[1:0])
               report("reach_status (typed)", status, rsp_payload.reach_status);
         end
      end
   end

   initial begin
      #3000000;
      $display("** leg_inverse_kinematics: FAILED **");
      $finish;
   end

   initial begin
      logic [15:0] geom [7][3];
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = CSR_COXA;
      csr_data = '0;
      coxa_len = COXA_RESET;
      femur_len = FEMUR_RESET;
      tibia_len = TIBIA_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: origin, extremes, zero reach distance
      add_target(0, 0, 0, REACH_OK);
      add_target(12800, 0, 0, REACH_OK);
      add_target(8388607, 8388607, 8388607, REACH_FAR);
      add_target(-8388608, -8388608, -8388608, REACH_FAR);
      add_target(-8388608, 0, 8388607, REACH_FAR);
      add_target(0, -8388608, 0, REACH_FAR);
      add_target(-100, 0, 0, -1);
      add_target(-100, -1, 0, -1);
      add_target(0, 12800, -20000, -1);
      add_target(64000, 0, 0, REACH_OK);
      add_target(64001, 0, 0, REACH_FAR);
      add_target(0, 0, -8388608, REACH_FAR);
      // too close and zero-length segments
      add_csr(CSR_FEMUR, 16'd2000);
      add_csr(CSR_TIBIA, 16'd30000);
      add_csr(CSR_SPARE, 16'hFFFF);
      add_target(12800, 0, 0, REACH_CLOSE);
      add_target(12800, 0, -5000, REACH_CLOSE);
      add_target(-12800, 0, 100, REACH_CLOSE);
      add_target(12800, 0, 31000, -1);
      add_csr(CSR_FEMUR, 16'd0);
      add_target(12800, 0, 0, -1);
      add_target(20000, 0, 0, -1);
      add_csr(CSR_TIBIA, 16'd0);
      add_target(12800, 0, 0, -1);
      add_target(12801, 0, 0, REACH_FAR);

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            drain();
            write_csr(rows[i].index, rows[i].data);
         end else begin
            send_request(rows[i].target, rows[i].status);
         end
      end

      geom = '{'{COXA_RESET, FEMUR_RESET, TIBIA_RESET},
               '{16'd0, 16'd1, 16'd1},
               '{16'hFFFF, 16'hFFFF, 16'hFFFF},
               '{16'd12800, 16'd2000, 16'd30000},
               '{16'd300, 16'd0, 16'd5000},
               '{16'd1000, 16'd4000, 16'd0},
               '{16'($urandom), 16'($urandom), 16'($urandom)}};
      for (int ph = 0; ph < 7; ph++) begin
         set_geometry(geom[ph][0], geom[ph][1], geom[ph][2]);
         calm = (ph == 2);
         if (ph == 4) write_csr(CSR_SPARE, 16'($urandom));
         for (int n = 0; n < 125; n++)
            send_request(random_target(), -1);
         calm = 1'b0;
      end

      drain();
      repeat (160) @(posedge clock);
      if (errors == 0) begin
         $display("** leg_inverse_kinematics: PASSED **");
      end else begin
         $display("** leg_inverse_kinematics: FAILED **");
      end
      $finish;
   end

endmodule
